// ----- hdl/telemetry_frame_serializer_assert.svh -----
// Assertion macros for the telemetry frame serializer.
// Uses the including module's clock and reset signals.
`ifndef TELEMETRY_FRAME_SERIALIZER_ASSERT_SVH
`define TELEMETRY_FRAME_SERIALIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TFS_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TFS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tfs_pkg.sv -----
// Package for the telemetry frame serializer: frame constants, scale
// factors, register indexes and byte positions. No dependencies.
`default_nettype none

package tfs_pkg;

   localparam int VALUE_W  = 32;
   localparam int WORD_W   = 16;
   localparam int SCALE_W  = 29;
   localparam int PROD_W   = VALUE_W + SCALE_W;
   localparam int NUM_WORDS = 6;
   localparam int POS_W    = 5;
   localparam int REQ_DATA_W = 200;

   // Unsigned Q13.16 scale factors
   localparam logic [SCALE_W-1:0] SCALE_ACCEL = 29'd6553600;
   localparam logic [SCALE_W-1:0] SCALE_RATE  = 29'd61520875;
   localparam logic [SCALE_W-1:0] SCALE_ANGLE = 29'd375493621;

   localparam logic [7:0] FRAME_HEAD   = 8'hAB;
   localparam logic [7:0] RESET_SOURCE = 8'hDD;
   localparam logic [7:0] RESET_DEST   = 8'hFE;
   localparam logic [7:0] ID_INERTIAL  = 8'h01;
   localparam logic [7:0] ID_ATTITUDE  = 8'h03;
   localparam logic [7:0] LEN_INERTIAL_DATA = 8'd13;
   localparam logic [7:0] LEN_ATTITUDE_DATA = 8'd7;
   localparam int LEN_INERTIAL = 21;
   localparam int LEN_ATTITUDE = 15;

   // Frame kinds
   localparam logic KIND_INERTIAL = 1'b0;
   localparam logic KIND_ATTITUDE = 1'b1;

   // Configuration register indexes
   localparam logic CSR_SOURCE = 1'b0;
   localparam logic CSR_DEST   = 1'b1;

   // Byte positions within a frame
   localparam logic [POS_W-1:0] POS_HEAD   = 5'd0;
   localparam logic [POS_W-1:0] POS_SOURCE = 5'd1;
   localparam logic [POS_W-1:0] POS_DEST   = 5'd2;
   localparam logic [POS_W-1:0] POS_ID     = 5'd3;
   localparam logic [POS_W-1:0] POS_LENGTH = 5'd4;
   localparam logic [POS_W-1:0] POS_PAD    = 5'd5;
   localparam logic [POS_W-1:0] POS_WORDS  = 5'd6;
   // Tail byte (pad or status) sits three before the end
   localparam logic [POS_W-1:0] TAIL_INERTIAL = POS_W'(LEN_INERTIAL - 3);
   localparam logic [POS_W-1:0] TAIL_ATTITUDE = POS_W'(LEN_ATTITUDE - 3);
   localparam logic [POS_W-1:0] LAST_INERTIAL = POS_W'(LEN_INERTIAL - 1);
   localparam logic [POS_W-1:0] LAST_ATTITUDE = POS_W'(LEN_ATTITUDE - 1);

   typedef logic [VALUE_W-1:0] mag_type;
   typedef logic [PROD_W-1:0]  prod_type;
   typedef logic [WORD_W-1:0]  word_type;

endpackage : tfs_pkg

`default_nettype wire

// ----- hdl/telemetry_frame_serializer.sv -----
// Telemetry frame serializer top level: scaling pipeline, frame buffer and
// byte serializer with dual 8-bit additive checksum. Depends on tfs_pkg and
// telemetry_frame_serializer_assert.svh.
//
// Path: a request's first frame byte reaches rsp_ through the input/magnitude,
//    product, word/frame buffer and output registers after it is accepted.
// Throughput: one byte per cycle while rsp_tready allows, for 21-byte inertial
//    and 15-byte attitude frames; frames follow each other with no gap. The byte
//    serializer over the frame buffer sets this figure.
// Reset: synchronous, active high; clears all valid flags, the byte counter
//    and the checksums, and loads source 0xDD and destination 0xFE.
`default_nettype none
`include "telemetry_frame_serializer_assert.svh"

module telemetry_frame_serializer
   import tfs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata from bit 0: primary_x[31:0], primary_y, primary_z, rate_x, rate_y,
   // rate_z, fusion_status[7:0] (bits 199:192)
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: op (0 inertial, 1 attitude)
   input  wire logic                  req_tuser,
   // Response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: frame_byte[7:0]
   output logic [7:0]                 rsp_tdata,
   // tlast: last_byte
   output logic                       rsp_tlast,
   // Register write port
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [7:0]            csr_data
);

   // ---------------- configuration registers ----------------
   logic [7:0] source_ff, source_in;
   logic [7:0] dest_ff, dest_in;

   assign csr_ready = 1'b1;

   always_comb begin
      source_in = source_ff;
      dest_in   = dest_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SOURCE: source_in = csr_data;
            CSR_DEST:   dest_in   = csr_data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= RESET_SOURCE;
         dest_ff   <= RESET_DEST;
      end else begin
         source_ff <= source_in;
         dest_ff   <= dest_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic ld1, ld2, ld3;
   logic out_ready, issue, done;
   logic [POS_W-1:0] last_pos;

   // Stage 1: magnitudes and signs of the six inputs
   mag_type  mag1_ff  [NUM_WORDS];
   mag_type  mag1_in  [NUM_WORDS];
   logic [NUM_WORDS-1:0] neg1_ff, neg1_in;
   logic     kind1_ff;
   logic [7:0] status1_ff;

   // Stage 2: exact products
   prod_type prod2_ff [NUM_WORDS];
   prod_type prod2_in [NUM_WORDS];
   logic [NUM_WORDS-1:0] neg2_ff;
   logic     kind2_ff;
   logic [7:0] status2_ff;

   // Stage 3: encoded words, held as the frame being serialized
   word_type word3_ff [NUM_WORDS];
   word_type word3_in [NUM_WORDS];
   logic     kind3_ff;
   logic [7:0] status3_ff;

   // Serializer state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] sos_ff, sos_in;

   // Output register
   logic       rsp_v_ff, rsp_v_in;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;

   logic [7:0] cur_byte;
   logic       cur_last;

   assign out_ready = !rsp_v_ff || rsp_tready;
   assign issue     = v3_ff && out_ready;
   assign last_pos  = (kind3_ff == KIND_ATTITUDE) ? LAST_ATTITUDE : LAST_INERTIAL;
   assign done      = issue && (pos_ff == last_pos);

   // The frame buffer frees up on the last byte, so frames run gapless
   assign ld3 = v2_ff && (!v3_ff || done);
   assign ld2 = v1_ff && (!v2_ff || ld3);
   assign req_tready = !v1_ff || ld2;
   assign ld1 = req_tvalid && req_tready;

   always_comb begin
      v1_in = ld1 ? 1'b1 : (ld2 ? 1'b0 : v1_ff);
      v2_in = ld2 ? 1'b1 : (ld3 ? 1'b0 : v2_ff);
      v3_in = ld3 ? 1'b1 : (done ? 1'b0 : v3_ff);
   end

   // ---------------- stage 1: sign and magnitude ----------------
   always_comb begin
      logic [VALUE_W-1:0] raw;
      for (int i = 0; i < NUM_WORDS; i++) begin
         raw = req_tdata[VALUE_W*i +: VALUE_W];
         neg1_in[i] = raw[VALUE_W-1];
         mag1_in[i] = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            mag1_ff[i] <= mag1_in[i];
         end
         neg1_ff    <= neg1_in;
         kind1_ff   <= req_tuser;
         status1_ff <= req_tdata[REQ_DATA_W-1 -: 8];
      end
   end

   // ---------------- stage 2: multiply by scale ----------------
   always_comb begin
      logic [SCALE_W-1:0] scale;
      for (int i = 0; i < NUM_WORDS; i++) begin
         if (i >= 3) begin
            scale = SCALE_RATE;
         end else if (kind1_ff == KIND_ATTITUDE) begin
            scale = SCALE_ANGLE;
         end else begin
            scale = SCALE_ACCEL;
         end
         prod2_in[i] = PROD_W'(mag1_ff[i]) * PROD_W'(scale);
      end
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            prod2_ff[i] <= prod2_in[i];
         end
         neg2_ff    <= neg1_ff;
         kind2_ff   <= kind1_ff;
         status2_ff <= status1_ff;
      end
   end

   // ---------------- stage 3: round half away, saturate to int16 ----------------
   always_comb begin
      prod_type rounded;
      logic [PROD_W-33:0] q;
      for (int i = 0; i < NUM_WORDS; i++) begin
         rounded = prod2_ff[i] + PROD_W'(64'h8000_0000);
         q = rounded[PROD_W-1:32];
         if (neg2_ff[i]) begin
            if (q >= (PROD_W-32)'(32768)) begin
               word3_in[i] = 16'h8000;
            end else begin
               word3_in[i] = ~q[WORD_W-1:0] + WORD_W'(1);
            end
         end else begin
            if (q > (PROD_W-32)'(32767)) begin
               word3_in[i] = 16'h7FFF;
            end else begin
               word3_in[i] = q[WORD_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            word3_ff[i] <= word3_in[i];
         end
         kind3_ff   <= kind2_ff;
         status3_ff <= status2_ff;
      end
   end

   // ---------------- byte serializer ----------------
   always_comb begin
      logic [POS_W-1:0] tail_pos;
      logic [POS_W-1:0] off;
      logic [2:0]       widx;
      word_type         w;
      tail_pos = (kind3_ff == KIND_ATTITUDE) ? TAIL_ATTITUDE : TAIL_INERTIAL;
      off  = pos_ff - POS_WORDS;
      widx = off[3:1];
      w    = (widx < 3'(NUM_WORDS)) ? word3_ff[widx] : '0;
      cur_last = (pos_ff == last_pos);
      case (pos_ff)
         POS_HEAD:   cur_byte = FRAME_HEAD;
         POS_SOURCE: cur_byte = source_ff;
         POS_DEST:   cur_byte = dest_ff;
         POS_ID:     cur_byte = (kind3_ff == KIND_ATTITUDE) ? ID_ATTITUDE : ID_INERTIAL;
         POS_LENGTH: cur_byte = (kind3_ff == KIND_ATTITUDE) ? LEN_ATTITUDE_DATA
                                                            : LEN_INERTIAL_DATA;
         POS_PAD:    cur_byte = 8'h00;
         default: begin
            if (pos_ff < tail_pos) begin
               cur_byte = off[0] ? w[15:8] : w[7:0];
            end else if (pos_ff == tail_pos) begin
               cur_byte = (kind3_ff == KIND_ATTITUDE) ? status3_ff : 8'h00;
            end else if (!cur_last) begin
               cur_byte = sum_ff;
            end else begin
               cur_byte = sos_ff;
            end
         end
      endcase

      pos_in = pos_ff;
      sum_in = sum_ff;
      sos_in = sos_ff;
      if (done) begin
         pos_in = '0;
         sum_in = '0;
         sos_in = '0;
      end else if (issue) begin
         pos_in = pos_ff + POS_W'(1);
         // checksums cover everything up to and including the tail byte
         if (pos_ff <= tail_pos) begin
            sum_in = sum_ff + cur_byte;
            sos_in = sos_ff + sum_in;
         end
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_v_in = rsp_v_ff;
      if (issue) begin
         rsp_v_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rsp_data_ff <= cur_byte;
         rsp_last_ff <= cur_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         pos_ff   <= '0;
         sum_ff   <= '0;
         sos_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         sos_ff   <= sos_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- assertions ----------------
   `TFS_ASSERT_NOW(a_pos_in_frame, v3_ff, pos_ff <= last_pos, "byte counter ran past frame end")
   `TFS_ASSERT_NOW(a_idle_clean, !v3_ff, (pos_ff == '0) && (sum_ff == '0) && (sos_ff == '0),
                   "serializer state not cleared between frames")
   `TFS_ASSERT_NEXT(a_last_flag, done, rsp_tvalid && rsp_tlast, "final byte lost its last flag")
   `TFS_ASSERT_NEXT(a_accept_holds, ld1, v1_ff, "accepted request not captured")

endmodule : telemetry_frame_serializer

`default_nettype wire

// ----- test/tfs_frame_checker.sv -----
`timescale 1ns / 100ps
// Frame checker for the telemetry frame serializer bench: follows register writes,
// predicts each frame from accepted requests and compares the byte stream.
// Depends on tfs_pkg only.
module tfs_frame_checker
   import tfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [7:0]            rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [7:0]            csr_data,
   output int                    error_count,
   output int                    bytes_pending
);

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_byte_type;

   frame_byte_type expected_bytes[$];
   logic [7:0]  source_addr;
   logic [7:0]  dest_addr;
   word_type    encoded[NUM_WORDS];
   logic [7:0]  status_copy;
   int          mismatches = 0;

   assign error_count = mismatches;

   // Q16.16 times unsigned Q13.16 scale, round half away from zero, clamp to int16
   function automatic word_type scale_word(input logic [31:0] bits,
                                           input logic [SCALE_W-1:0] factor);
      logic [63:0] magnitude;
      logic [63:0] rounded;
      magnitude = bits[31] ? {32'd0, ~bits} + 64'd1 : {32'd0, bits};
      rounded = (magnitude * {35'd0, factor} + 64'h8000_0000) >> 32;
      if (bits[31])
         return (rounded >= 64'd32768) ? 16'h8000 : 16'(~rounded[15:0] + 16'd1);
      return (rounded > 64'd32767) ? 16'h7FFF : rounded[15:0];
   endfunction

   task automatic predict_frame(input logic kind, input logic [REQ_DATA_W-1:0] fields);
      logic [7:0] frame[LEN_INERTIAL];
      int         length;
      int         word_count;
      logic [7:0] running_sum;
      logic [7:0] sum_of_sums;
      if (kind == KIND_INERTIAL) begin
         for (int i = 0; i < 3; i++)
            encoded[i] = scale_word(fields[32*i +: 32], SCALE_ACCEL);
         for (int i = 3; i < 6; i++)
            encoded[i] = scale_word(fields[32*i +: 32], SCALE_RATE);
         length     = LEN_INERTIAL;
         word_count = 6;
      end else begin
         for (int i = 0; i < 3; i++)
            encoded[i] = scale_word(fields[32*i +: 32], SCALE_ANGLE);
         status_copy = fields[199:192];
         length      = LEN_ATTITUDE;
         word_count  = 3;
      end
      frame[0] = FRAME_HEAD;
      frame[1] = source_addr;
      frame[2] = dest_addr;
      frame[3] = (kind == KIND_INERTIAL) ? ID_INERTIAL : ID_ATTITUDE;
      frame[4] = (kind == KIND_INERTIAL) ? LEN_INERTIAL_DATA : LEN_ATTITUDE_DATA;
      frame[5] = 8'h00;
      for (int i = 0; i < word_count; i++) begin
         frame[6 + 2*i] = encoded[i][7:0];
         frame[7 + 2*i] = encoded[i][15:8];
      end
      frame[6 + 2*word_count] = (kind == KIND_INERTIAL) ? 8'h00 : status_copy;
      running_sum = 8'h00;
      sum_of_sums = 8'h00;
      for (int i = 0; i < length - 2; i++) begin
         running_sum = running_sum + frame[i];
         sum_of_sums = sum_of_sums + running_sum;
      end
      frame[length - 2] = running_sum;
      frame[length - 1] = sum_of_sums;
      for (int i = 0; i < length; i++)
         expected_bytes.push_back('{frame[i], (i == length - 1)});
   endtask

   always @(posedge clock) begin
      frame_byte_type want;
      if (reset) begin
         source_addr = RESET_SOURCE;
         dest_addr   = RESET_DEST;
         status_copy = 8'h00;
         for (int i = 0; i < NUM_WORDS; i++)
            encoded[i] = '0;
         expected_bytes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SOURCE)
               source_addr = csr_data;
            else if (csr_index == CSR_DEST)
               dest_addr = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected frame byte %02h last %0b", $time, rsp_tdata,
                        rsp_tlast);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.frame_byte) begin
                  mismatches++;
                  $display("%0t: frame byte expected %02h actual %02h", $time,
                           want.frame_byte, rsp_tdata);
               end
               if (rsp_tlast !== want.last_byte) begin
                  mismatches++;
                  $display("%0t: last flag expected %0b actual %0b", $time,
                           want.last_byte, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_frame(req_tuser, req_tdata);
      end
      bytes_pending <= expected_bytes.size();
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Bench top for the telemetry frame serializer: clock, reset, address writes,
// sample requests, byte-side backpressure and the verdict.
// Depends on tfs_pkg, telemetry_frame_serializer and tfs_frame_checker.
module tb_top;
   import tfs_pkg::*;

   localparam int HOLD_CYCLES = 400;   // long byte-side stall, fills the block
   localparam int TAIL_CYCLES = 20;    // quiet time after the last byte

   typedef enum logic [2:0] {
      STAGE_RESET,
      STAGE_DIRECTED,
      STAGE_RX_SLOW,
      STAGE_TX_SLOW,
      STAGE_BACKLOG,
      STAGE_FULL_RATE
   } stage_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tdata from bit 0: primary_x, primary_y, primary_z, rate_x, rate_y, rate_z,
   // fusion_status
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // tuser: op
   logic                  req_tuser = KIND_INERTIAL;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata: frame_byte
   logic [7:0]            rsp_tdata;
   // tlast: last_byte
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = CSR_SOURCE;
   logic [7:0]            csr_data = 8'h00;

   logic      rsp_hold = 1'b0;
   int        send_idle_pct = 8;
   int        recv_idle_pct = 73;
   stage_type stage = STAGE_RESET;
   int        error_count;
   int        bytes_pending;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   telemetry_frame_serializer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tfs_frame_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .bytes_pending (bytes_pending)
   );

   // Byte-side ready: random stalls at the current rate, forced low during a hold
   always @(posedge clock) begin
      if (reset || rsp_hold)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Long stall in the backlog stage, counted here while the sender keeps going
   initial begin
      wait (stage == STAGE_BACKLOG);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Offers one request; tvalid is left high so back-to-back requests never
   // drop it. A gap, if drawn, lowers tvalid before the offer.
   task automatic send_sample(input logic kind,
                              input logic [31:0] px, py, pz, rx, ry, rz,
                              input logic [7:0] status);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {status, rz, ry, rx, pz, py, px};
      do @(posedge clock); while (!req_tready);
   endtask

   // Mix of raw words, extremes, rounding ties and values up to just beyond the int16
   // range of each of the three scales
   function automatic logic [31:0] random_value();
      int unsigned limit;
      case ($urandom_range(4))
         0: return $urandom();
         1: begin
            case ($urandom_range(5))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               4: return 32'h0000_2000;
               default: return 32'hFFFF_E000;
            endcase
         end
         default: begin
            case ($urandom_range(2))
               0: limit = 380_000;       // angle
               1: limit = 2_300_000;     // rate
               default: limit = 22_000_000;  // acceleration
            endcase
            return 32'($urandom_range(2 * limit)) - limit;
         end
      endcase
   endfunction

   task automatic send_random();
      send_sample(1'($urandom_range(1)), random_value(), random_value(), random_value(),
                  random_value(), random_value(), random_value(), 8'($urandom()));
   endtask

   // Sender pause: nothing offered until every predicted byte has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (bytes_pending != 0);
   endtask

   task automatic write_addresses(input logic [7:0] source, input logic [7:0] dest);
      csr_valid <= 1'b1;
      csr_index <= CSR_SOURCE;
      csr_data  <= source;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_DEST;
      csr_data  <= dest;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset addresses
      stage <= STAGE_DIRECTED;
      send_sample(KIND_INERTIAL, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'h00);
      send_sample(KIND_ATTITUDE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'h00);
      // positive and negative saturation on every word
      send_sample(KIND_INERTIAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF);
      send_sample(KIND_INERTIAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h00);
      // rate fields are don't-care in the attitude frame kind
      send_sample(KIND_ATTITUDE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF);
      send_sample(KIND_ATTITUDE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h00);
      // 0.125 * 100 = 12.5: rounding tie both ways; one-LSB values round to 0
      send_sample(KIND_INERTIAL, 32'h0000_2000, 32'hFFFF_E000, 32'h0000_2000,
                  32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 8'h3C);
      send_sample(KIND_ATTITUDE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h0, 32'h0, 32'h0, 8'h5A);
      // just inside and just beyond the int16 range per scale
      send_sample(KIND_INERTIAL, 32'h0147_AE14, 32'h0147_AD00, 32'hFEB8_51EC,
                  32'h0022_E000, 32'hFFDD_2000, 32'h0023_0000, 8'h00);
      send_sample(KIND_ATTITUDE, 32'h0005_B800, 32'hFFFA_4800, 32'h0005_C000,
                  32'h0, 32'h0, 32'h0, 8'hA5);
      // bit toggles
      send_sample(KIND_INERTIAL, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 8'h55);
      send_sample(KIND_ATTITUDE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 8'hC3);
      // unit values: 100 m/s^2 counts and 939 rate counts
      send_sample(KIND_INERTIAL, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                  32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 8'h00);
      // +-pi and pi/2 in centidegrees
      send_sample(KIND_ATTITUDE, 32'h0003_243F, 32'hFFFC_DBC1, 32'h0001_921F,
                  32'h0, 32'h0, 32'h0, 8'h01);
      wait_drained();

      // Slow receiver, addresses at opposite extremes
      stage <= STAGE_RX_SLOW;
      write_addresses(8'h00, 8'hFF);
      repeat (100) send_random();
      wait_drained();

      // Slow sender, fast receiver
      stage         <= STAGE_TX_SLOW;
      send_idle_pct <= 73;
      recv_idle_pct <= 8;
      write_addresses(8'hFF, 8'h00);
      repeat (100) send_random();
      wait_drained();

      // Backlog: the byte side is held off while requests keep coming
      stage         <= STAGE_BACKLOG;
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      write_addresses(8'($urandom()), 8'($urandom()));
      repeat (40) send_random();
      wait_drained();

      // Full rate on both sides
      stage <= STAGE_FULL_RATE;
      write_addresses(8'($urandom()), 8'($urandom()));
      repeat (56) send_random();
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
